/* rtl/ffra_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the first-fit range allocator.
// Used by ffra_alu and first_fit_range_allocator_unit; depends on nothing.
package ffra_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_BITS   = 24;
  localparam int LEN_W       = ADDR_BITS + 1;
  localparam int ALU_W       = ADDR_BITS + 2;

  localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(16777216);

  // One free region of the list
  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0]     length;
  } entry_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NO_FIT = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_ZERO   = 2'd3
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Request to the shared add/subtract/compare unit
  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] cmp;
  } alu_req_t;

  // Response: result, borrow (a < b on subtract), result equals cmp
  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             borrow;
    logic             eq;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC_FIX,
    ST_FREE_JN,
    ST_FREE_JP,
    ST_FREE_ADD1,
    ST_FREE_ADD2,
    ST_FREE_WR,
    ST_SHIFT_DN,
    ST_SHIFT_UP,
    ST_DONE
  } state_t;

endpackage

/* rtl/ffra_alu.sv */
`timescale 1ns / 1ps
// Shared add/subtract and equality compare unit of the allocator sequencer.
// Depends on ffra_pkg for the request and response structs.
module ffra_alu (
  input  ffra_pkg::alu_req_t req,
  output ffra_pkg::alu_rsp_t rsp
);

  logic [ffra_pkg::ALU_W:0] full;

  // Add or subtract with one extra bit to catch the borrow
  always_comb begin
    unique case (req.op)
      ffra_pkg::ALU_SUB: full = {1'b0, req.a} - {1'b0, req.b};
      default:           full = {1'b0, req.a} + {1'b0, req.b};
    endcase
  end

  // Flag borrow and compare against the reference operand
  always_comb begin
    rsp.res    = full[ffra_pkg::ALU_W-1:0];
    rsp.borrow = (req.op == ffra_pkg::ALU_SUB) && full[ffra_pkg::ALU_W];
    rsp.eq     = (full[ffra_pkg::ALU_W-1:0] == req.cmp);
  end

endmodule

/* rtl/first_fit_range_allocator_unit.sv */
`timescale 1ns / 1ps
// First-fit range allocator: top level with sequencer and free-list memory.
// Depends on ffra_pkg and ffra_alu.
//
// Keeps the free regions of [0, total_capacity) as an address-sorted list of up to
// 64 entries in a memory with one write and one registered read per cycle.
// An allocate walks the list one entry a cycle and takes the first region that is
// large enough, trimming its front or removing it; a free walks to its place in
// address order and merges with the touching neighbors or inserts a new entry.
// The walk and the entry moves share the one memory port and together touch each
// list entry at most once. A zero-size item goes straight to the done state with
// no walk. The next item is taken in the idle state that follows the load of the
// result. One item is in work at a time; a finished result sits in the output
// register while the next item is taken. After reset and after each total_capacity
// write the list is rebuilt in the init state, during which no item or write is
// taken.
module first_fit_range_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [24:0] total_capacity,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [24:0] region_size,
  input  logic [23:0] region_start,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [23:0] alloc_start
);

  localparam int IW = ffra_pkg::IDX_W;
  localparam int CW = ffra_pkg::CNT_W;
  localparam int AB = ffra_pkg::ADDR_BITS;
  localparam int LW = ffra_pkg::LEN_W;
  localparam int AW = ffra_pkg::ALU_W;

  ffra_pkg::state_t state, state_next;

  // Free-list memory
  ffra_pkg::entry_t list_mem [ffra_pkg::MAX_REGIONS];
  ffra_pkg::entry_t rd_data;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  ffra_pkg::entry_t wr_data;

  // Request and working registers
  logic [LW-1:0]     cap, cap_next;
  logic [CW-1:0]     count, count_next;
  ffra_pkg::op_t     req_op, req_op_next;
  logic [LW-1:0]     req_size, req_size_next;
  logic [AB-1:0]     req_start, req_start_next;
  logic [CW-1:0]     idx, idx_next;
  logic [CW-1:0]     pos, pos_next;
  ffra_pkg::entry_t  prev_ent, prev_ent_next;
  ffra_pkg::entry_t  next_ent, next_ent_next;
  logic              next_ok, next_ok_next;
  logic              join_next, join_next_next;
  logic              join_prev, join_prev_next;
  logic              hit_exact, hit_exact_next;
  logic [LW-1:0]     hit_diff, hit_diff_next;
  logic [AW-1:0]     acc, acc_next;
  ffra_pkg::status_t res_status, res_status_next;
  logic [AB-1:0]     res_start, res_start_next;

  ffra_pkg::alu_req_t alu_req;
  ffra_pkg::alu_rsp_t alu_rsp;

  logic in_fire, cfg_fire, out_fire, out_load;
  logic scan_end, shift_dn_end;
  logic is_alloc;

  ffra_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Handshakes
  assign cfg_ready    = (state == ffra_pkg::ST_IDLE);
  assign in_stall     = (state != ffra_pkg::ST_IDLE) || cfg_valid;
  assign cfg_fire     = cfg_valid && cfg_ready;
  assign in_fire      = in_valid && !in_stall;
  assign out_fire     = out_valid && !out_stall;
  assign out_load     = (state == ffra_pkg::ST_DONE) && (!out_valid || !out_stall);
  assign is_alloc     = (req_op == ffra_pkg::OP_ALLOC);
  assign scan_end     = (idx >= count);
  assign shift_dn_end = ((idx + CW'(1)) >= count);

  // Memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      list_mem[wr_addr] <= wr_data;
    end
    rd_data <= list_mem[rd_addr];
  end

  // Operand select for the shared unit
  always_comb begin
    alu_req = '{op: ffra_pkg::ALU_ADD, a: '0, b: '0, cmp: '0};
    unique case (state)
      ffra_pkg::ST_SCAN: begin
        alu_req.op = ffra_pkg::ALU_SUB;
        if (is_alloc) begin
          alu_req.a = AW'(rd_data.length);
          alu_req.b = AW'(req_size);
        end else begin
          alu_req.a = AW'(rd_data.start);
          alu_req.b = AW'(req_start);
        end
      end
      ffra_pkg::ST_ALLOC_FIX: begin
        alu_req.a = AW'(res_start);
        alu_req.b = AW'(req_size);
      end
      ffra_pkg::ST_FREE_JN: begin
        alu_req.a   = AW'(req_start);
        alu_req.b   = AW'(req_size);
        alu_req.cmp = AW'(next_ent.start);
      end
      ffra_pkg::ST_FREE_JP: begin
        alu_req.a   = AW'(prev_ent.start);
        alu_req.b   = AW'(prev_ent.length);
        alu_req.cmp = AW'(req_start);
      end
      ffra_pkg::ST_FREE_ADD1: begin
        alu_req.a = AW'(req_size);
        alu_req.b = join_prev ? AW'(prev_ent.length) : AW'(next_ent.length);
      end
      ffra_pkg::ST_FREE_ADD2: begin
        alu_req.a = acc;
        alu_req.b = AW'(next_ent.length);
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffra_pkg::ST_INIT: state_next = ffra_pkg::ST_IDLE;
      ffra_pkg::ST_IDLE: begin
        if (cfg_fire) begin
          state_next = ffra_pkg::ST_INIT;
        end else if (in_fire) begin
          state_next = (region_size == '0) ? ffra_pkg::ST_DONE : ffra_pkg::ST_SCAN;
        end
      end
      ffra_pkg::ST_SCAN: begin
        if (scan_end || !alu_rsp.borrow) begin
          if (is_alloc) begin
            state_next = scan_end ? ffra_pkg::ST_DONE : ffra_pkg::ST_ALLOC_FIX;
          end else begin
            state_next = ffra_pkg::ST_FREE_JN;
          end
        end
      end
      ffra_pkg::ST_ALLOC_FIX:
        state_next = hit_exact ? ffra_pkg::ST_SHIFT_DN : ffra_pkg::ST_DONE;
      ffra_pkg::ST_FREE_JN: state_next = ffra_pkg::ST_FREE_JP;
      ffra_pkg::ST_FREE_JP: state_next = ffra_pkg::ST_FREE_ADD1;
      ffra_pkg::ST_FREE_ADD1: begin
        if (!join_next && !join_prev) begin
          state_next = (count >= CW'(ffra_pkg::MAX_REGIONS)) ? ffra_pkg::ST_DONE
                                                            : ffra_pkg::ST_SHIFT_UP;
        end else if (join_next && join_prev) begin
          state_next = ffra_pkg::ST_FREE_ADD2;
        end else begin
          state_next = ffra_pkg::ST_FREE_WR;
        end
      end
      ffra_pkg::ST_FREE_ADD2: state_next = ffra_pkg::ST_FREE_WR;
      ffra_pkg::ST_FREE_WR:
        state_next = (join_next && join_prev) ? ffra_pkg::ST_SHIFT_DN : ffra_pkg::ST_DONE;
      ffra_pkg::ST_SHIFT_DN: if (shift_dn_end) state_next = ffra_pkg::ST_DONE;
      ffra_pkg::ST_SHIFT_UP: if (idx == pos) state_next = ffra_pkg::ST_DONE;
      ffra_pkg::ST_DONE: if (out_load) state_next = ffra_pkg::ST_IDLE;
      default: state_next = ffra_pkg::ST_INIT;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cap_next        = cap;
    count_next      = count;
    req_op_next     = req_op;
    req_size_next   = req_size;
    req_start_next  = req_start;
    idx_next        = idx;
    pos_next        = pos;
    prev_ent_next   = prev_ent;
    next_ent_next   = next_ent;
    next_ok_next    = next_ok;
    join_next_next  = join_next;
    join_prev_next  = join_prev;
    hit_exact_next  = hit_exact;
    hit_diff_next   = hit_diff;
    acc_next        = acc;
    res_status_next = res_status;
    res_start_next  = res_start;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '{start: '0, length: cap};

    unique case (state)
      // Rebuild the list as one region covering the whole range
      ffra_pkg::ST_INIT: begin
        wr_en      = 1'b1;
        count_next = (cap != '0) ? CW'(1) : '0;
      end
      // Latch a write or a request; prefetch entry 0
      ffra_pkg::ST_IDLE: begin
        if (cfg_fire) begin
          cap_next = total_capacity;
        end else if (in_fire) begin
          req_op_next     = ffra_pkg::op_t'(op);
          req_size_next   = region_size;
          req_start_next  = region_start;
          idx_next        = '0;
          res_start_next  = '0;
          res_status_next = (region_size == '0) ? ffra_pkg::STATUS_ZERO
                                                : ffra_pkg::STATUS_OK;
        end
      end
      // Walk one entry per cycle
      ffra_pkg::ST_SCAN: begin
        rd_addr = IW'(idx + CW'(1));
        if (scan_end) begin
          if (is_alloc) begin
            res_status_next = ffra_pkg::STATUS_NO_FIT;
          end else begin
            pos_next     = idx;
            next_ok_next = 1'b0;
          end
        end else if (!alu_rsp.borrow) begin
          if (is_alloc) begin
            res_start_next = rd_data.start;
            hit_diff_next  = alu_rsp.res[LW-1:0];
            hit_exact_next = alu_rsp.eq;
          end else begin
            pos_next      = idx;
            next_ent_next = rd_data;
            next_ok_next  = 1'b1;
          end
        end else begin
          prev_ent_next = rd_data;
          idx_next      = idx + CW'(1);
        end
      end
      // Trim the front of the hit, or start removing it
      ffra_pkg::ST_ALLOC_FIX: begin
        if (hit_exact) begin
          rd_addr = IW'(idx + CW'(1));
        end else begin
          wr_en   = 1'b1;
          wr_addr = IW'(idx);
          wr_data = '{start: alu_rsp.res[AB-1:0], length: hit_diff};
        end
      end
      ffra_pkg::ST_FREE_JN: join_next_next = next_ok && alu_rsp.eq;
      ffra_pkg::ST_FREE_JP: join_prev_next = (pos != '0) && alu_rsp.eq;
      ffra_pkg::ST_FREE_ADD1: begin
        acc_next = alu_rsp.res;
        if (!join_next && !join_prev) begin
          if (count >= CW'(ffra_pkg::MAX_REGIONS)) begin
            res_status_next = ffra_pkg::STATUS_FULL;
          end else begin
            idx_next = count;
            rd_addr  = IW'(count - CW'(1));
          end
        end
      end
      ffra_pkg::ST_FREE_ADD2: acc_next = alu_rsp.res;
      // Write the merged region
      ffra_pkg::ST_FREE_WR: begin
        wr_en = 1'b1;
        if (join_prev) begin
          wr_addr = IW'(pos - CW'(1));
          wr_data = '{start: prev_ent.start, length: acc[LW-1:0]};
          if (join_next) begin
            rd_addr  = IW'(pos + CW'(1));
            idx_next = pos;
          end
        end else begin
          wr_addr = IW'(pos);
          wr_data = '{start: req_start, length: acc[LW-1:0]};
        end
      end
      // Move entries down over the removed one
      ffra_pkg::ST_SHIFT_DN: begin
        if (shift_dn_end) begin
          count_next = count - CW'(1);
        end else begin
          wr_en    = 1'b1;
          wr_addr  = IW'(idx);
          wr_data  = rd_data;
          rd_addr  = IW'(idx + CW'(2));
          idx_next = idx + CW'(1);
        end
      end
      // Move entries up to open a hole, then drop the new region in
      ffra_pkg::ST_SHIFT_UP: begin
        wr_en = 1'b1;
        if (idx == pos) begin
          wr_addr    = IW'(pos);
          wr_data    = '{start: req_start, length: req_size};
          count_next = count + CW'(1);
        end else begin
          wr_addr  = IW'(idx);
          wr_data  = rd_data;
          rd_addr  = IW'(idx - CW'(2));
          idx_next = idx - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffra_pkg::ST_INIT;
      cap       <= ffra_pkg::CAP_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cap   <= cap_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_op     <= req_op_next;
    req_size   <= req_size_next;
    req_start  <= req_start_next;
    idx        <= idx_next;
    pos        <= pos_next;
    prev_ent   <= prev_ent_next;
    next_ent   <= next_ent_next;
    next_ok    <= next_ok_next;
    join_next  <= join_next_next;
    join_prev  <= join_prev_next;
    hit_exact  <= hit_exact_next;
    hit_diff   <= hit_diff_next;
    acc        <= acc_next;
    res_status <= res_status_next;
    res_start  <= res_start_next;
    if (out_load) begin
      status      <= res_status;
      alloc_start <= (res_status == ffra_pkg::STATUS_OK) ? res_start : '0;
    end
  end

`ifndef SYNTHESIS
  // List never holds more entries than the memory has rows
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ffra_pkg::MAX_REGIONS))
    else $error("free list count past capacity");

  // Insertion only starts with room left
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == ffra_pkg::ST_SHIFT_UP) |-> (count < CW'(ffra_pkg::MAX_REGIONS)))
    else $error("insert into full free list");

  // Removal only works on a live entry
  a_remove_live: assert property (@(posedge clk) disable iff (rst)
    (state == ffra_pkg::ST_SHIFT_DN) |-> (idx < count))
    else $error("remove past end of free list");

  // A new result beat comes only out of the done state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ffra_pkg::ST_DONE))
    else $error("result raised outside done state");
`endif

endmodule
